[rtl/level_gamma_colormap_pixel_core_assert.svh]
// assertion macros used by the colormap palette module
// both expect clk_i and rst_ni in the scope of use
`ifndef LEVEL_GAMMA_COLORMAP_PIXEL_CORE_ASSERT_SVH
`define LEVEL_GAMMA_COLORMAP_PIXEL_CORE_ASSERT_SVH
// consequent holds in the same cycle
`define LGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// consequent holds in the next cycle
`define LGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/lgc_pkg.sv]
// ----------------------------------------------------------------------------
// lgc_pkg
// Shared widths, codes, item tag and root constants of the colormap pipeline.
// ----------------------------------------------------------------------------
package lgc_pkg;

  localparam int FracBits     = 16;
  localparam int PaletteDepth = 256;
  localparam int SampleW      = 18;
  localparam int LevelW       = 17;
  localparam int GammaW       = 16;
  localparam int GammaFrac    = 12;
  localparam int LevelsW      = 9;
  localparam int ColorW       = 32;
  localparam int EntryW       = 8;
  localparam int CfgIdxW      = 3;
  localparam int MagW         = FracBits + 5;
  localparam int TW           = MagW + GammaW - GammaFrac;
  localparam int RootBits     = 30;
  localparam int VW           = RootBits + 1;
  localparam int ShW          = 10;

  // item kinds
  localparam logic KindSample = 1'b0;
  localparam logic KindWrite  = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgBlack  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWhite  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGamma  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLevels = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBack   = 3'd4;

  typedef enum logic [1:0] {
    PathPower = 2'd0,
    PathOne   = 2'd1,
    PathZero  = 2'd2,
    PathBack  = 2'd3
  } path_e;

  typedef struct packed {
    logic                kind;
    path_e               path;
    logic [EntryW-1:0]   entry_index;
    logic [ColorW-1:0]   entry_color;
  } tag_t;

  // integer square root, rounded down
  function automatic logic [63:0] isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(2^-(k+1)) scaled by 2^30
  function automatic logic [63:0] root_const(input int k);
    logic [63:0] c;
    c = isqrt(64'd1 << 61);
    for (int i = 0; i < 24; i++) begin
      if (i < k) c = isqrt(c << RootBits);
    end
    return c;
  endfunction

endpackage

[rtl/lgc_divider.sv]
// ----------------------------------------------------------------------------
// lgc_divider
// Pipelined restoring divider, one quotient bit per stage: (d << F) / w.
// ----------------------------------------------------------------------------
module lgc_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  lgc_pkg::tag_t                   tag_i,
  input  logic [lgc_pkg::LevelW-1:0]      d_i,
  input  logic [lgc_pkg::LevelW-1:0]      w_i,
  output logic                            valid_o,
  output lgc_pkg::tag_t                   tag_o,
  output logic [lgc_pkg::FracBits-1:0]    quo_o
);

  localparam int N = lgc_pkg::FracBits;
  localparam int RW = lgc_pkg::LevelW;

  logic          vld_q [N];
  lgc_pkg::tag_t tag_q [N];
  logic [RW-1:0] rem_q [N];
  logic [RW-1:0] w_q   [N];
  logic [N-1:0]  quo_q [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    logic          vld_s;
    lgc_pkg::tag_t tag_s;
    logic [RW-1:0] rem_s;
    logic [RW-1:0] w_s;
    logic [N-1:0]  quo_s;
    logic [RW:0]   rem_n;
    logic [RW:0]   sub;
    logic          ge;

    if (j == 0) begin : g_first
      assign vld_s = valid_i;
      assign tag_s = tag_i;
      assign rem_s = d_i;
      assign w_s   = w_i;
      assign quo_s = '0;
    end else begin : g_next
      assign vld_s = vld_q[j-1];
      assign tag_s = tag_q[j-1];
      assign rem_s = rem_q[j-1];
      assign w_s   = w_q[j-1];
      assign quo_s = quo_q[j-1];
    end

    // shift in one bit and try to subtract the divisor
    always_comb begin
      rem_n = {rem_s, 1'b0};
      sub   = rem_n - {1'b0, w_s};
      ge    = rem_n >= {1'b0, w_s};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[j] <= tag_s;
        w_q[j]   <= w_s;
        rem_q[j] <= ge ? sub[RW-1:0] : rem_n[RW-1:0];
        quo_q[j] <= {quo_s[N-2:0], ge};
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign tag_o   = tag_q[N-1];
  assign quo_o   = quo_q[N-1];

endmodule

[rtl/lgc_log2.sv]
// ----------------------------------------------------------------------------
// lgc_log2
// Pipelined log2 magnitude: normalize, one squaring per fraction bit, combine.
// ----------------------------------------------------------------------------
module lgc_log2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  lgc_pkg::tag_t                 tag_i,
  input  logic [lgc_pkg::FracBits-1:0]  r_i,
  output logic                          valid_o,
  output lgc_pkg::tag_t                 tag_o,
  output logic [lgc_pkg::MagW-1:0]      mag_o
);

  localparam int F  = lgc_pkg::FracBits;
  localparam int MW = F + 1;
  localparam int IW = lgc_pkg::MagW - F;

  // normalize stage
  logic          n_vld_q;
  lgc_pkg::tag_t n_tag_q;
  logic [MW-1:0] n_m_q;
  logic [IW-1:0] n_int_q;

  logic [3:0]    lz;
  logic [MW-1:0] m0;
  lgc_pkg::tag_t tag_n;

  // leading zero count and path update for a zero ratio
  always_comb begin
    lz = 4'd0;
    for (int i = 0; i < F; i++) begin
      if (r_i[i]) lz = 4'(F - 1 - i);
    end
    m0    = {1'b0, r_i} << (IW'(lz) + IW'(1));
    tag_n = tag_i;
    if (tag_i.path == lgc_pkg::PathPower && r_i == '0) tag_n.path = lgc_pkg::PathZero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else if (en_i) begin
      n_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_tag_q <= tag_n;
      n_m_q   <= m0;
      n_int_q <= IW'(lz) + IW'(1);
    end
  end

  // squaring stages
  logic          vld_q  [F];
  lgc_pkg::tag_t tag_q  [F];
  logic [MW-1:0] m_q    [F];
  logic [IW-1:0] int_q  [F];
  logic [F-1:0]  frac_q [F];

  for (genvar j = 0; j < F; j++) begin : g_sq
    logic            vld_s;
    lgc_pkg::tag_t   tag_s;
    logic [MW-1:0]   m_s;
    logic [IW-1:0]   int_s;
    logic [F-1:0]    frac_s;
    logic [2*MW-1:0] sq;
    logic [MW:0]     s;

    if (j == 0) begin : g_first
      assign vld_s  = n_vld_q;
      assign tag_s  = n_tag_q;
      assign m_s    = n_m_q;
      assign int_s  = n_int_q;
      assign frac_s = '0;
    end else begin : g_next
      assign vld_s  = vld_q[j-1];
      assign tag_s  = tag_q[j-1];
      assign m_s    = m_q[j-1];
      assign int_s  = int_q[j-1];
      assign frac_s = frac_q[j-1];
    end

    always_comb begin
      sq = (2*MW)'(m_s) * (2*MW)'(m_s);
      s  = sq[2*MW-1:F];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_s;
      end
    end

    // square at or above two gives a one bit and halves
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[j]  <= tag_s;
        int_q[j]  <= int_s;
        m_q[j]    <= s[MW] ? s[MW:1] : s[MW-1:0];
        frac_q[j] <= {frac_s[F-2:0], s[MW]};
      end
    end
  end

  // combine integer and fraction parts
  logic          o_vld_q;
  lgc_pkg::tag_t o_tag_q;
  logic [lgc_pkg::MagW-1:0] o_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      o_vld_q <= vld_q[F-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_tag_q <= tag_q[F-1];
      o_mag_q <= {int_q[F-1], {F{1'b0}}} - {{IW{1'b0}}, frac_q[F-1]};
    end
  end

  assign valid_o = o_vld_q;
  assign tag_o   = o_tag_q;
  assign mag_o   = o_mag_q;

endmodule

[rtl/lgc_exp2.sv]
// ----------------------------------------------------------------------------
// lgc_exp2
// Gamma scaling and pipelined exp2 by root constants, one bit per stage.
// ----------------------------------------------------------------------------
module lgc_exp2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  lgc_pkg::tag_t                 tag_i,
  input  logic [lgc_pkg::MagW-1:0]      mag_i,
  input  logic [lgc_pkg::GammaW-1:0]    gamma_i,
  output logic                          valid_o,
  output lgc_pkg::tag_t                 tag_o,
  output logic [lgc_pkg::FracBits:0]    p_o
);

  localparam int F   = lgc_pkg::FracBits;
  localparam int TW  = lgc_pkg::TW;
  localparam int VW  = lgc_pkg::VW;
  localparam int RB  = lgc_pkg::RootBits;
  localparam int ShW = lgc_pkg::ShW;
  localparam int PrW = lgc_pkg::MagW + lgc_pkg::GammaW;

  // gamma multiply stage
  logic          t_vld_q;
  lgc_pkg::tag_t t_tag_q;
  logic [TW-1:0] t_q;
  logic [PrW-1:0] prod;

  assign prod = PrW'(mag_i) * PrW'(gamma_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= 1'b0;
    end else if (en_i) begin
      t_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_tag_q <= tag_i;
      t_q     <= prod[PrW-1:lgc_pkg::GammaFrac];
    end
  end

  // split into integer shift and fraction complement
  logic           g_vld_q;
  lgc_pkg::tag_t  g_tag_q;
  logic [F-1:0]   g_q;
  logic [ShW-1:0] sh_q;
  logic [F-1:0]   f_s;
  logic [F:0]     g_full;
  logic           fz;

  always_comb begin
    f_s    = t_q[F-1:0];
    fz     = (f_s == '0);
    g_full = (F+1)'(1 << F) - {1'b0, f_s};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en_i) begin
      g_vld_q <= t_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_tag_q <= t_tag_q;
      g_q     <= fz ? '0 : g_full[F-1:0];
      sh_q    <= ShW'(RB - F) + ShW'(t_q[TW-1:F]) + (fz ? ShW'(0) : ShW'(1));
    end
  end

  // one conditional root multiply per stage
  logic           vld_q [F];
  lgc_pkg::tag_t  tag_q [F];
  logic [VW-1:0]  v_q   [F];
  logic [F-1:0]   gb_q  [F];
  logic [ShW-1:0] shs_q [F];

  for (genvar k = 0; k < F; k++) begin : g_step
    localparam logic [VW-1:0] Root = VW'(lgc_pkg::root_const(k));
    logic            vld_s;
    lgc_pkg::tag_t   tag_s;
    logic [VW-1:0]   v_s;
    logic [F-1:0]    g_s;
    logic [ShW-1:0]  sh_s;
    logic [2*VW-1:0] mul;

    if (k == 0) begin : g_first
      assign vld_s = g_vld_q;
      assign tag_s = g_tag_q;
      assign v_s   = VW'(1) << RB;
      assign g_s   = g_q;
      assign sh_s  = sh_q;
    end else begin : g_next
      assign vld_s = vld_q[k-1];
      assign tag_s = tag_q[k-1];
      assign v_s   = v_q[k-1];
      assign g_s   = gb_q[k-1];
      assign sh_s  = shs_q[k-1];
    end

    assign mul = (2*VW)'(v_s) * (2*VW)'(Root);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k] <= tag_s;
        gb_q[k]  <= g_s;
        shs_q[k] <= sh_s;
        v_q[k]   <= g_s[F-1-k] ? mul[RB+VW-1:RB] : v_s;
      end
    end
  end

  // final shift and path select
  logic          o_vld_q;
  lgc_pkg::tag_t o_tag_q;
  logic [F:0]    o_p_q;
  logic [VW-1:0] shifted;
  logic [F:0]    p_n;

  always_comb begin
    shifted = (shs_q[F-1] >= ShW'(VW)) ? '0 : (v_q[F-1] >> shs_q[F-1]);
    case (tag_q[F-1].path)
      lgc_pkg::PathOne:   p_n = (F+1)'(1 << F);
      lgc_pkg::PathPower: p_n = shifted[F:0];
      default:            p_n = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      o_vld_q <= vld_q[F-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_tag_q <= tag_q[F-1];
      o_p_q   <= p_n;
    end
  end

  assign valid_o = o_vld_q;
  assign tag_o   = o_tag_q;
  assign p_o     = o_p_q;

endmodule

[rtl/lgc_palette.sv]
// ----------------------------------------------------------------------------
// lgc_palette
// Palette index scaling, palette memory and the output register.
// ----------------------------------------------------------------------------
`include "level_gamma_colormap_pixel_core_assert.svh"

module lgc_palette #(
  parameter int DEPTH = lgc_pkg::PaletteDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  lgc_pkg::tag_t                 tag_i,
  input  logic [lgc_pkg::FracBits:0]    p_i,
  input  logic [lgc_pkg::LevelsW-1:0]   levels_i,
  input  logic [lgc_pkg::ColorW-1:0]    background_i,
  output logic                          out_valid_o,
  output logic [lgc_pkg::ColorW-1:0]    pixel_color_o,
  output logic                          is_background_o
);

  localparam int F    = lgc_pkg::FracBits;
  localparam int IdxW = $clog2(DEPTH);
  localparam int LvW  = $clog2(DEPTH + 1);
  localparam int PW   = F + 1 + IdxW;

  // clamp the level count and scale the powered value
  logic [LvW-1:0]  lv;
  logic [IdxW-1:0] lm1;
  logic [PW-1:0]   prod;
  logic [IdxW:0]   sc;
  logic [IdxW-1:0] idx_n;

  always_comb begin
    if (levels_i == '0) begin
      lv = LvW'(1);
    end else if (32'(levels_i) > 32'(DEPTH)) begin
      lv = LvW'(DEPTH);
    end else begin
      lv = LvW'(levels_i);
    end
    lm1   = IdxW'(lv - LvW'(1));
    prod  = PW'(p_i) * PW'(lm1);
    sc    = prod[PW-1:F];
    idx_n = (sc > {1'b0, lm1}) ? lm1 : sc[IdxW-1:0];
  end

  logic            i_vld_q;
  lgc_pkg::tag_t   i_tag_q;
  logic [IdxW-1:0] idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_vld_q <= 1'b0;
    end else if (en_i) begin
      i_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      i_tag_q <= tag_i;
      idx_q   <= idx_n;
    end
  end

  // palette write items update the memory in item order
  logic [lgc_pkg::ColorW-1:0] mem [DEPTH];
  logic [lgc_pkg::ColorW-1:0] rdata_q;
  logic [31:0]                ent32;
  logic [IdxW-1:0]            widx;
  logic                       do_write;
  logic                       is_sample;

  always_comb begin
    ent32     = 32'(i_tag_q.entry_index);
    widx      = ent32[IdxW-1:0];
    do_write  = i_vld_q && (i_tag_q.kind == lgc_pkg::KindWrite) && (ent32 < 32'(DEPTH));
    is_sample = i_vld_q && (i_tag_q.kind == lgc_pkg::KindSample);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (do_write) mem[widx] <= i_tag_q.entry_color;
      rdata_q <= mem[idx_q];
    end
  end

  // output register
  logic out_valid_q;
  logic bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= is_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bg_q <= (i_tag_q.path == lgc_pkg::PathBack);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_background_o = bg_q;
  assign pixel_color_o   = bg_q ? background_i : rdata_q;

  `LGC_ASSERT_NEXT(a_write_no_result, en_i && i_vld_q && i_tag_q.kind == lgc_pkg::KindWrite, !out_valid_q, "palette write produced a result")
  `LGC_ASSERT_NOW(a_index_in_range, is_sample, idx_q <= lm1, "palette index beyond levels in use")
  `LGC_ASSERT_NEXT(a_back_flag, en_i && is_sample && i_tag_q.path == lgc_pkg::PathBack, out_valid_q && bg_q, "no-data sample lost its background flag")

endmodule

[rtl/level_gamma_colormap_pixel_core.sv]
// ----------------------------------------------------------------------------
// level_gamma_colormap_pixel_core
// Levels, gamma and palette lookup for one amplitude sample per item.
// ----------------------------------------------------------------------------
// One item enters every clock unless the pipeline holds, and each result
// passes one input stage, sixteen divider stages, eighteen log2 stages
// (normalize, sixteen squarings, combine), nineteen exp2 stages (gamma
// multiply, split, sixteen root multiplies, shift) and two palette stages
// (index scaling, memory read). The whole pipeline holds while a result waits
// on a stall. Palette write items (kind 1) travel the same pipeline and write
// the memory at the read stage, so they take effect in item order and give no
// result. Palette entries must be written before they are used. The user must
// write registers only while the pipeline is empty; the block does not check it.
// ----------------------------------------------------------------------------
module level_gamma_colormap_pixel_core #(
  parameter int PALETTE_DEPTH = lgc_pkg::PaletteDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lgc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lgc_pkg::ColorW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic signed [lgc_pkg::SampleW-1:0] sample_i,
  input  logic [lgc_pkg::EntryW-1:0]     entry_index_i,
  input  logic [lgc_pkg::ColorW-1:0]     entry_color_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lgc_pkg::ColorW-1:0]     pixel_color_o,
  output logic                           is_background_o
);

  localparam int LW = lgc_pkg::LevelW;
  localparam int SW = lgc_pkg::SampleW;

  // configuration registers
  logic [LW-1:0]                  black_q;
  logic [LW-1:0]                  white_q;
  logic [lgc_pkg::GammaW-1:0]     gamma_q;
  logic [lgc_pkg::LevelsW-1:0]    levels_q;
  logic [lgc_pkg::ColorW-1:0]     back_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q  <= '0;
      white_q  <= LW'(65536);
      gamma_q  <= lgc_pkg::GammaW'(4096);
      levels_q <= lgc_pkg::LevelsW'(256);
      back_q   <= 32'hFF26_2626;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lgc_pkg::CfgBlack:  black_q  <= cfg_data_i[LW-1:0];
        lgc_pkg::CfgWhite:  white_q  <= cfg_data_i[LW-1:0];
        lgc_pkg::CfgGamma:  gamma_q  <= cfg_data_i[lgc_pkg::GammaW-1:0];
        lgc_pkg::CfgLevels: levels_q <= cfg_data_i[lgc_pkg::LevelsW-1:0];
        lgc_pkg::CfgBack:   back_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global pipeline enable
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // classify the sample against the levels
  logic          ge_white;
  logic          le_black;
  logic          nonneg;
  logic [SW-1:0] diff;
  lgc_pkg::tag_t tag_n;

  always_comb begin
    ge_white = sample_i >= $signed({1'b0, white_q});
    le_black = sample_i <= $signed({1'b0, black_q});
    nonneg   = !sample_i[SW-1];
    diff     = sample_i - $signed({1'b0, black_q});
    tag_n.kind        = kind_i;
    tag_n.entry_index = entry_index_i;
    tag_n.entry_color = entry_color_i;
    if (ge_white) begin
      tag_n.path = lgc_pkg::PathOne;
    end else if (nonneg && le_black) begin
      tag_n.path = lgc_pkg::PathZero;
    end else if (nonneg) begin
      tag_n.path = lgc_pkg::PathPower;
    end else begin
      tag_n.path = lgc_pkg::PathBack;
    end
  end

  logic          s0_vld_q;
  lgc_pkg::tag_t s0_tag_q;
  logic [LW-1:0] s0_d_q;
  logic [LW-1:0] s0_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_tag_q <= tag_n;
      s0_d_q   <= diff[LW-1:0];
      s0_w_q   <= white_q - black_q;
    end
  end

  // ratio
  logic                           dv_vld;
  lgc_pkg::tag_t                  dv_tag;
  logic [lgc_pkg::FracBits-1:0]   dv_quo;

  lgc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_vld_q),
    .tag_i   (s0_tag_q),
    .d_i     (s0_d_q),
    .w_i     (s0_w_q),
    .valid_o (dv_vld),
    .tag_o   (dv_tag),
    .quo_o   (dv_quo)
  );

  // log2 magnitude
  logic                       lg_vld;
  lgc_pkg::tag_t              lg_tag;
  logic [lgc_pkg::MagW-1:0]   lg_mag;

  lgc_log2 u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_vld),
    .tag_i   (dv_tag),
    .r_i     (dv_quo),
    .valid_o (lg_vld),
    .tag_o   (lg_tag),
    .mag_o   (lg_mag)
  );

  // gamma power
  logic                         ex_vld;
  lgc_pkg::tag_t                ex_tag;
  logic [lgc_pkg::FracBits:0]   ex_p;

  lgc_exp2 u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lg_vld),
    .tag_i   (lg_tag),
    .mag_i   (lg_mag),
    .gamma_i (gamma_q),
    .valid_o (ex_vld),
    .tag_o   (ex_tag),
    .p_o     (ex_p)
  );

  // palette lookup and output
  lgc_palette #(
    .DEPTH (PALETTE_DEPTH)
  ) u_pal (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (ex_vld),
    .tag_i           (ex_tag),
    .p_i             (ex_p),
    .levels_i        (levels_q),
    .background_i    (back_q),
    .out_valid_o     (out_valid_o),
    .pixel_color_o   (pixel_color_o),
    .is_background_o (is_background_o)
  );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the levels, gamma and palette colormap core. A
// scoreboard class mirrors the black/white/gamma/levels registers and the
// palette, predicts the color of every accepted sample item, and checks each
// result in order. Several register settings are swept, idle between phases,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module testbench;

  // register index outside the map, written once to show it is ignored
  localparam logic [lgc_pkg::CfgIdxW-1:0] CfgUnmapped = 3'd5;
  localparam int IdleLimit  = 3000;
  localparam int DrainWait  = 64;
  localparam int PhaseItems = 100;

  typedef struct {
    logic [lgc_pkg::ColorW-1:0] color;
    logic                       background;
  } pixel_t;

  // predicts pixel colors and checks results against them
  class colormap_scoreboard;
    int                         black_pt;
    int                         white_pt;
    int                         gamma_q;
    int                         levels_raw;
    logic [lgc_pkg::ColorW-1:0] back_color;
    logic [lgc_pkg::ColorW-1:0] palette_mem [lgc_pkg::PaletteDepth];
    bit                         written [lgc_pkg::PaletteDepth];
    longint unsigned            roots [24];
    pixel_t                     pending_pixels [$];
    int                         mismatches;

    function new();
      black_pt   = 0;
      white_pt   = 65536;
      gamma_q    = 4096;
      levels_raw = 256;
      back_color = 32'hFF26_2626;
      mismatches = 0;
      foreach (written[i]) written[i] = 0;
      roots[0] = floor_sqrt(64'd1 << 61);
      for (int k = 1; k < 24; k++) roots[k] = floor_sqrt(roots[k-1] << lgc_pkg::RootBits);
    endfunction

    // bitwise search for floor of the square root
    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned cand;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
        cand = res | (64'd1 << b);
        if (cand * cand <= v) res = cand;
      end
      return res;
    endfunction

    function void write_register(logic [lgc_pkg::CfgIdxW-1:0] idx,
                                 logic [lgc_pkg::ColorW-1:0] data);
      case (idx)
        lgc_pkg::CfgBlack:  black_pt   = int'(data[lgc_pkg::LevelW-1:0]);
        lgc_pkg::CfgWhite:  white_pt   = int'(data[lgc_pkg::LevelW-1:0]);
        lgc_pkg::CfgGamma:  gamma_q    = int'(data[lgc_pkg::GammaW-1:0]);
        lgc_pkg::CfgLevels: levels_raw = int'(data[lgc_pkg::LevelsW-1:0]);
        lgc_pkg::CfgBack:   back_color = data;
        default: ;
      endcase
    endfunction

    // (d / w) ^ gamma in Q.16 through log2 and exp2
    function longint unsigned gamma_power(longint unsigned d, longint unsigned w);
      longint unsigned r, m, frac, mag, t, n, f, v, sh, g;
      int e;
      r = (d << lgc_pkg::FracBits) / w;
      if (r == 0) return 0;
      e = lgc_pkg::FracBits - 1;
      while (((r >> e) & 1) == 0) e--;
      m = r << (lgc_pkg::FracBits - e);
      frac = 0;
      for (int i = 0; i < lgc_pkg::FracBits; i++) begin
        m = (m * m) >> lgc_pkg::FracBits;
        frac = frac << 1;
        if (m >= (64'd2 << lgc_pkg::FracBits)) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      mag = longint'(lgc_pkg::FracBits - e) * (64'd1 << lgc_pkg::FracBits) - frac;
      t = (mag * longint'(gamma_q)) >> lgc_pkg::GammaFrac;
      n = t >> lgc_pkg::FracBits;
      f = t & ((64'd1 << lgc_pkg::FracBits) - 1);
      v = 64'd1 << lgc_pkg::RootBits;
      if (f == 0) begin
        sh = lgc_pkg::RootBits - lgc_pkg::FracBits + n;
      end else begin
        g = (64'd1 << lgc_pkg::FracBits) - f;
        for (int k = 1; k <= lgc_pkg::FracBits; k++)
          if ((g >> (lgc_pkg::FracBits - k)) & 1) v = (v * roots[k-1]) >> lgc_pkg::RootBits;
        sh = lgc_pkg::RootBits - lgc_pkg::FracBits + n + 1;
      end
      if (sh >= 63) return 0;
      return v >> sh;
    endfunction

    // palette slot a sample reads, -1 for no-data
    function int slot_for(logic signed [lgc_pkg::SampleW-1:0] smp);
      int x, lv;
      longint unsigned p, idx;
      x  = int'(smp);
      lv = levels_raw < 1 ? 1 : (levels_raw > lgc_pkg::PaletteDepth ? lgc_pkg::PaletteDepth
                                                                     : levels_raw);
      if (x >= white_pt) p = 64'd1 << lgc_pkg::FracBits;
      else if (x >= 0 && x <= black_pt) p = 0;
      else if (x >= 0) p = gamma_power(longint'(x - black_pt), longint'(white_pt - black_pt));
      else return -1;
      idx = (p * longint'(lv - 1)) >> lgc_pkg::FracBits;
      if (idx > longint'(lv - 1)) idx = lv - 1;
      return int'(idx);
    endfunction

    function void note_item(logic kind, logic signed [lgc_pkg::SampleW-1:0] smp,
                            logic [lgc_pkg::EntryW-1:0] eidx,
                            logic [lgc_pkg::ColorW-1:0] ecolor);
      pixel_t px;
      int slot;
      if (kind == lgc_pkg::KindWrite) begin
        palette_mem[eidx] = ecolor;
        written[eidx] = 1;
        return;
      end
      slot = slot_for(smp);
      if (slot < 0) begin
        px.color = back_color;
        px.background = 1;
      end else begin
        px.color = palette_mem[slot];
        px.background = 0;
      end
      pending_pixels.push_back(px);
    endfunction

    function void check_pixel(logic [lgc_pkg::ColorW-1:0] color, logic background);
      pixel_t px;
      if (pending_pixels.size() == 0) begin
        $error("result with nothing expected: pixel_color %h", color);
        mismatches++;
        return;
      end
      px = pending_pixels.pop_front();
      if (color !== px.color) begin
        $error("pixel_color expected %h actual %h", px.color, color);
        mismatches++;
      end
      if (background !== px.background) begin
        $error("is_background expected %b actual %b", px.background, background);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [lgc_pkg::CfgIdxW-1:0]        cfg_index_i;
  logic [lgc_pkg::ColorW-1:0]         cfg_data_i;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic                               kind_i;
  logic signed [lgc_pkg::SampleW-1:0] sample_i;
  logic [lgc_pkg::EntryW-1:0]         entry_index_i;
  logic [lgc_pkg::ColorW-1:0]         entry_color_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic [lgc_pkg::ColorW-1:0]         pixel_color_o;
  logic                               is_background_o;

  colormap_scoreboard sb;
  int  idle_cycles;
  bit  in_quiet;
  bit  out_quiet;
  int  out_hold;

  level_gamma_colormap_pixel_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .kind_i, .sample_i, .entry_index_i, .entry_color_i,
    .out_valid_o, .out_stall_i, .pixel_color_o, .is_background_o
  );

  // clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // output stalls, bursts mostly short with a few long ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 0;
      out_hold    <= 0;
    end else if (out_hold > 0) begin
      out_stall_i <= 1;
      out_hold    <= out_hold - 1;
    end else if (!out_quiet && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1;
      out_hold    <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                 : $urandom_range(0, 2);
    end else begin
      out_stall_i <= 0;
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_pixel(pixel_color_o, is_background_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic send_item(logic kind, logic signed [lgc_pkg::SampleW-1:0] smp,
                           logic [lgc_pkg::EntryW-1:0] eidx,
                           logic [lgc_pkg::ColorW-1:0] ecolor);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap = in_quiet ? 0 : (pick < 60 ? 0 : (pick < 92 ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40)));
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1;
    kind_i        <= kind;
    sample_i      <= smp;
    entry_index_i <= eidx;
    entry_color_i <= ecolor;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(kind, smp, eidx, ecolor);
  endtask

  // a sample item, preceded by a palette write if its slot is still blank
  task automatic send_sample(logic signed [lgc_pkg::SampleW-1:0] smp);
    int slot;
    slot = sb.slot_for(smp);
    if (slot >= 0 && !sb.written[slot])
      send_item(lgc_pkg::KindWrite, lgc_pkg::SampleW'($urandom),
                lgc_pkg::EntryW'(slot), $urandom);
    send_item(lgc_pkg::KindSample, smp, lgc_pkg::EntryW'($urandom), $urandom);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // write enable stays high across back to back writes, the caller drops it
  task automatic set_reg(logic [lgc_pkg::CfgIdxW-1:0] idx, logic [lgc_pkg::ColorW-1:0] data);
    cfg_we_i    <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_register(idx, data);
  endtask

  task automatic set_levels(int blk, int wht, int gam, int lv,
                            logic [lgc_pkg::ColorW-1:0] bk);
    drain();
    set_reg(lgc_pkg::CfgBlack, blk);
    set_reg(lgc_pkg::CfgWhite, wht);
    set_reg(lgc_pkg::CfgGamma, gam);
    set_reg(lgc_pkg::CfgLevels, lv);
    set_reg(lgc_pkg::CfgBack, bk);
    cfg_we_i <= 0;
  endtask

  // random sample, weighted toward the power path
  function automatic logic signed [lgc_pkg::SampleW-1:0] pick_sample();
    int pick;
    int lo, hi;
    pick = $urandom_range(0, 99);
    lo = sb.black_pt;
    hi = sb.white_pt > sb.black_pt ? sb.white_pt : sb.black_pt;
    if (pick < 25) return lgc_pkg::SampleW'($urandom);
    if (pick < 35) return lgc_pkg::SampleW'(-$urandom_range(1, 131072));
    if (pick < 42) return lgc_pkg::SampleW'($urandom_range(hi > 131071 ? 131071 : hi, 131071));
    return lgc_pkg::SampleW'($urandom_range(lo, hi > 131071 ? 131071 : hi));
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) in_quiet = $urandom_range(0, 2) == 0;
      if ($urandom_range(0, 19) == 0) out_quiet = $urandom_range(0, 2) == 0;
      if ($urandom_range(0, 6) == 0)
        send_item(lgc_pkg::KindWrite, lgc_pkg::SampleW'($urandom),
                  lgc_pkg::EntryW'($urandom), $urandom);
      else send_sample(pick_sample());
    end
  endtask

  initial begin
    sb = new();
    idle_cycles   = 0;
    in_quiet      = 0;
    out_quiet     = 0;
    rst_ni        = 0;
    cfg_we_i      = 0;
    cfg_index_i   = lgc_pkg::CfgBlack;
    cfg_data_i    = '0;
    in_valid_i    = 0;
    kind_i        = lgc_pkg::KindSample;
    sample_i      = '0;
    entry_index_i = '0;
    entry_color_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: palette extremes, field extremes, boundaries
    set_levels(0, 65536, 4096, 256, 32'hFF26_2626);
    send_item(lgc_pkg::KindWrite, '0, 8'd0, 32'h0000_0000);
    send_item(lgc_pkg::KindWrite, '1, 8'd255, 32'hFFFF_FFFF);
    send_sample(18'sd0);
    send_sample(18'sd1);
    send_sample(-18'sd1);
    send_sample(-18'sd131072);
    send_sample(18'sd131071);
    send_sample(18'sd65536);
    send_sample(18'sd65535);
    send_sample(18'sd32768);
    send_sample(18'sd21845);
    send_sample(18'sd43690);
    random_phase(PhaseItems);

    set_levels(0, 65536, 65535, 256, 32'h0000_0000);
    send_sample(18'sd65535);
    send_sample(18'sd1);
    random_phase(PhaseItems);

    set_levels(16384, 49152, 1, 255, 32'hFFFF_FFFF);
    send_sample(18'sd16384);
    send_sample(18'sd16385);
    send_sample(18'sd49151);
    send_sample(18'sd49152);
    random_phase(PhaseItems);

    // white not above black never reaches the power path
    set_levels(65536, 0, 4096, 1, 32'h1234_5678);
    send_sample(18'sd0);
    send_sample(18'sd65536);
    random_phase(PhaseItems);

    // zero gamma, widest white, levels beyond the palette
    set_levels(1000, 131071, 0, 511, 32'h8000_0001);
    random_phase(PhaseItems);

    set_levels(0, 65536, 8192, 0, 32'h00FF_00FF);
    random_phase(PhaseItems);

    set_levels(32768, 32769, 2048, 128, 32'hFF00_FF00);
    send_sample(18'sd32768);
    random_phase(PhaseItems);

    set_levels($urandom_range(0, 30000), $urandom_range(35000, 65536),
               $urandom_range(1, 65535), $urandom_range(2, 256), $urandom);
    set_reg(CfgUnmapped, $urandom);
    cfg_we_i <= 0;
    random_phase(PhaseItems);

    drain();
    if (sb.mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/lgc_pkg.sv
rtl/lgc_divider.sv
rtl/lgc_log2.sv
rtl/lgc_exp2.sv
rtl/lgc_palette.sv
rtl/level_gamma_colormap_pixel_core.sv
bench/testbench.sv
